// File: design/slpq_pkg.sv
// Shared constants and types for the sorted-list priority queue.
// No dependencies; used by slpq_cell and sorted_list_priority_queue.
package slpq_pkg;

    localparam int DATA_W        = 32;
    localparam int OCC_W         = 5;
    localparam int DEFAULT_DEPTH = 16;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    // broadcast from the top level to every cell in the chain
    typedef struct packed {
        logic                     insert;
        logic                     pop;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctrl;

endpackage

// File: design/sorted_list_priority_queue.sv
// Top level of the sorted-list priority queue: chain of slpq_cell
// instances, entry counter and output register.
// Depends on slpq_pkg and slpq_cell.
//
//  channel  | valid   | ready   | payload
//  ---------+---------+---------+-------------------------------------------
//  request  | i_valid | o_ready | i_req_type, i_value_in
//  result   | o_valid | i_ready | o_value_out, o_found, o_rejected,
//           |         |         | o_occupancy
//
// One request per cycle while the output register is free: every cell
// compares against the broadcast value and shifts by one place in the
// same cycle. The result appears in the cycle after acceptance and
// waits in the output register; a new request is taken whenever that
// register is empty or is being drained. Synchronous reset empties the
// queue (count only; entry contents stay undefined).
module sorted_list_priority_queue #(
    parameter int DEPTH = slpq_pkg::DEFAULT_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_req_type,
    input  logic signed [slpq_pkg::DATA_W-1:0] i_value_in,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [slpq_pkg::DATA_W-1:0] o_value_out,
    output logic                               o_found,
    output logic                               o_rejected,
    output logic [slpq_pkg::OCC_W-1:0]         o_occupancy
);

    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;

    logic                               r_out_valid;
    logic signed [slpq_pkg::DATA_W-1:0] r_value_out;
    logic                               r_found;
    logic                               r_rejected;
    logic [slpq_pkg::OCC_W-1:0]         r_occupancy;

    logic accept;
    logic full;
    logic empty;
    logic do_insert;
    logic do_pop;

    slpq_pkg::t_cell_ctrl ctrl;

    logic                               cell_gt    [DEPTH];
    logic signed [slpq_pkg::DATA_W-1:0] cell_value [DEPTH];

    // request decode
    assign o_ready   = !r_out_valid || i_ready;
    assign accept    = i_valid && o_ready;
    assign full      = (r_count == FULL_COUNT);
    assign empty     = (r_count == '0);
    assign do_insert = accept && (i_req_type == slpq_pkg::REQ_INSERT) && !full;
    assign do_pop    = accept && (i_req_type == slpq_pkg::REQ_POP) && !empty;

    assign ctrl.insert = do_insert;
    assign ctrl.pop    = do_pop;
    assign ctrl.value  = i_value_in;

    // cell chain, head at index 0
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        localparam logic [COUNT_W-1:0] IDX = COUNT_W'(gi);
        logic                               prev_gt;
        logic signed [slpq_pkg::DATA_W-1:0] prev_value;
        logic signed [slpq_pkg::DATA_W-1:0] next_value;

        if (gi == 0) begin : g_head
            assign prev_gt    = 1'b0;
            assign prev_value = i_value_in;
        end else begin : g_body
            assign prev_gt    = cell_gt[gi-1];
            assign prev_value = cell_value[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign next_value = cell_value[gi];
        end else begin : g_inner
            assign next_value = cell_value[gi+1];
        end

        slpq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_occupied   (r_count > IDX),
            .i_prev_gt    (prev_gt),
            .i_prev_value (prev_value),
            .i_next_value (next_value),
            .o_gt         (cell_gt[gi]),
            .o_value      (cell_value[gi])
        );
    end

    // entry count
    always_comb begin
        n_count = r_count;
        if (do_insert) begin
            n_count = r_count + COUNT_W'(1);
        end else if (do_pop) begin
            n_count = r_count - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value_out <= do_pop ? cell_value[0] : '0;
            r_found     <= do_pop;
            r_rejected  <= (i_req_type == slpq_pkg::REQ_INSERT) && full;
            r_occupancy <= slpq_pkg::OCC_W'(n_count);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value_out = r_value_out;
    assign o_found     = r_found;
    assign o_rejected  = r_rejected;
    assign o_occupancy = r_occupancy;

endmodule

// File: design/slpq_cell.sv
// One storage cell of the sorted chain: holds a single entry.
// Depends on slpq_pkg (DATA_W, t_cell_ctrl).
module slpq_cell (
    input  logic                              i_clk,
    input  slpq_pkg::t_cell_ctrl              i_ctrl,
    input  logic                              i_occupied,
    input  logic                              i_prev_gt,
    input  logic signed [slpq_pkg::DATA_W-1:0] i_prev_value,
    input  logic signed [slpq_pkg::DATA_W-1:0] i_next_value,
    output logic                              o_gt,
    output logic signed [slpq_pkg::DATA_W-1:0] o_value
);

    logic signed [slpq_pkg::DATA_W-1:0] r_value;
    logic signed [slpq_pkg::DATA_W-1:0] n_value;

    // empty cells count as larger than any value, so the insert slot is
    // the first cell that is greater or empty
    assign o_gt    = !i_occupied || (r_value > i_ctrl.value);
    assign o_value = r_value;

    // insert: take the new value at the boundary, shift up above it
    // pop: shift down one place toward the head
    always_comb begin
        n_value = r_value;
        if (i_ctrl.insert && o_gt) begin
            n_value = i_prev_gt ? i_prev_value : i_ctrl.value;
        end else if (i_ctrl.pop) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule
